// File: rtl/core/mtfal_pkg.sv
// types and constants shared by the move-to-front attention list
`default_nettype none

package mtfal_pkg;

    typedef enum logic [2:0] {
        ACT_SHIFT     = 3'd0,
        ACT_STOP      = 3'd1,
        ACT_EVOKE     = 3'd2,
        ACT_REFER     = 3'd3,
        ACT_EMBED     = 3'd4,
        ACT_ELABORATE = 3'd5,
        ACT_CONNECT   = 3'd6,
        ACT_ASSIGN    = 3'd7
    } t_action;

    localparam int unsigned IDX_BITS    = 5;
    localparam int unsigned FIELD_BITS  = 32;
    localparam int unsigned LEN_BITS    = 8;

    typedef struct packed {
        t_action                action;
        logic [FIELD_BITS-1:0]  main_handle;
        logic [FIELD_BITS-1:0]  other_handle;
        logic [LEN_BITS-1:0]    span_length;
        logic [FIELD_BITS-1:0]  role_handle;
        logic [FIELD_BITS-1:0]  label_handle;
    } t_in_item;

    typedef struct packed {
        t_action                out_action;
        logic [LEN_BITS-1:0]    out_length;
        logic [FIELD_BITS-1:0]  out_label;
        logic [FIELD_BITS-1:0]  out_role;
        logic [IDX_BITS-1:0]    source_index;
        logic [IDX_BITS-1:0]    target_index;
        logic [IDX_BITS-1:0]    max_index;
        logic                   lookup_miss;
        logic                   list_full_drop;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/core/mtfal_stream_if.sv
// valid/ready stream interface carrying one payload struct
`default_nettype none

interface mtfal_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/core/move_to_front_attention_list.sv
// move-to-front attention list of frame handles
//
// Channels: i_in takes one action transaction per cycle (valid/ready), o_out
// gives one result transaction for every action, in order. Each action is
// translated against the list as it stands: named handles become positions,
// then the list is updated (insert or move to front).
// Path: an accepted action is held in the input register, and its result in
// the result register, which drives o_out. Throughput is one action per cycle
// while o_out is not stalled: the compare of both handles against every list
// entry, the priority pick and the shift of the list are combinational from
// the input register to the result register, with the list held in flip-flops.
// Reset: entry count, running maximum and both valid flags clear; list
// contents are not cleared, entries past the count are never matched.
// Stall: when o_out.ready is low the result holds, the input register keeps
// one more action, and then i_in.ready drops until the result is taken.
`default_nettype none

module move_to_front_attention_list #(
    parameter int unsigned LIST_DEPTH  = 32,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    mtfal_stream_if.sink          i_in,
    mtfal_stream_if.source        o_out
);

    localparam int unsigned PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned XW = (PW > mtfal_pkg::IDX_BITS) ? PW : mtfal_pkg::IDX_BITS;
    localparam int unsigned IW = mtfal_pkg::IDX_BITS;

    logic                                   r_in_vld;
    mtfal_pkg::t_in_item                    r_in;
    logic                                   r_out_vld;
    mtfal_pkg::t_out_item                   r_out;
    logic [LIST_DEPTH-1:0][HANDLE_BITS-1:0] r_list;
    logic [CW-1:0]                          r_count;
    logic [IW-1:0]                          r_largest;

    mtfal_pkg::t_out_item                   n_out;
    logic [LIST_DEPTH-1:0][HANDLE_BITS-1:0] n_list;
    logic [CW-1:0]                          n_count;
    logic [IW-1:0]                          n_largest;

    logic                   advance;
    logic [HANDLE_BITS-1:0] fh;
    logic [HANDLE_BITS-1:0] oh;
    logic                   fh_found;
    logic                   oh_found;
    logic [PW-1:0]          fh_pos;
    logic [PW-1:0]          oh_pos;
    logic [IW-1:0]          fh_rep;
    logic [IW-1:0]          oh_rep;
    logic                   do_move;
    logic [PW-1:0]          move_pos;
    logic                   count_inc;
    logic [IW-1:0]          big_st;

    function automatic logic [IW-1:0] sat_pos(input logic [PW-1:0] pos);
        logic [XW-1:0] posx;
        posx = XW'(pos);
        sat_pos = (posx > XW'({IW{1'b1}})) ? {IW{1'b1}} : posx[IW-1:0];
    endfunction

    // two-stage flow control
    assign advance     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = i_rst_n && (!r_in_vld || advance);
    assign o_out.valid = r_out_vld;
    assign o_out.payload = r_out;

    assign fh = HANDLE_BITS'(r_in.main_handle);
    assign oh = HANDLE_BITS'(r_in.other_handle);

    mtfal_lookup #(
        .LIST_DEPTH  (LIST_DEPTH),
        .HANDLE_BITS (HANDLE_BITS),
        .PW          (PW),
        .CW          (CW)
    ) u_look_fh (
        .i_list   (r_list),
        .i_count  (r_count),
        .i_handle (fh),
        .o_found  (fh_found),
        .o_pos    (fh_pos)
    );

    mtfal_lookup #(
        .LIST_DEPTH  (LIST_DEPTH),
        .HANDLE_BITS (HANDLE_BITS),
        .PW          (PW),
        .CW          (CW)
    ) u_look_oh (
        .i_list   (r_list),
        .i_count  (r_count),
        .i_handle (oh),
        .o_found  (oh_found),
        .o_pos    (oh_pos)
    );

    assign fh_rep = fh_found ? sat_pos(fh_pos) : '0;
    assign oh_rep = oh_found ? sat_pos(oh_pos) : '0;

    // translate the action against the current list
    always_comb begin
        n_out            = '0;
        n_out.out_action = r_in.action;
        case (r_in.action)
            mtfal_pkg::ACT_EVOKE: begin
                n_out.out_length = r_in.span_length;
                n_out.out_label  = r_in.label_handle;
            end
            mtfal_pkg::ACT_REFER: begin
                n_out.out_length   = r_in.span_length;
                n_out.target_index = fh_rep;
                n_out.lookup_miss  = !fh_found;
            end
            mtfal_pkg::ACT_EMBED: begin
                n_out.out_label    = r_in.label_handle;
                n_out.out_role     = r_in.role_handle;
                n_out.target_index = oh_rep;
                n_out.lookup_miss  = !oh_found;
            end
            mtfal_pkg::ACT_ELABORATE: begin
                n_out.out_label    = r_in.label_handle;
                n_out.out_role     = r_in.role_handle;
                n_out.source_index = oh_rep;
                n_out.lookup_miss  = !oh_found;
            end
            mtfal_pkg::ACT_CONNECT: begin
                n_out.out_role     = r_in.role_handle;
                n_out.source_index = fh_rep;
                n_out.target_index = oh_rep;
                n_out.lookup_miss  = !fh_found || !oh_found;
            end
            mtfal_pkg::ACT_ASSIGN: begin
                n_out.out_label    = r_in.label_handle;
                n_out.out_role     = r_in.role_handle;
                n_out.source_index = fh_rep;
                n_out.lookup_miss  = !fh_found;
            end
            default: begin
            end
        endcase

        big_st    = (n_out.source_index > n_out.target_index) ?
                    n_out.source_index : n_out.target_index;
        n_largest = (big_st > r_largest) ? big_st : r_largest;
        n_out.max_index = n_largest;

        // list update plan
        do_move   = 1'b0;
        move_pos  = '0;
        count_inc = 1'b0;
        case (r_in.action)
            mtfal_pkg::ACT_EVOKE,
            mtfal_pkg::ACT_EMBED,
            mtfal_pkg::ACT_ELABORATE: begin
                do_move = 1'b1;
                if (fh_found) begin
                    move_pos = fh_pos;
                end else if (r_count == CW'(LIST_DEPTH)) begin
                    // full list: oldest entry falls off the end
                    move_pos             = PW'(LIST_DEPTH - 1);
                    n_out.list_full_drop = 1'b1;
                end else begin
                    move_pos  = r_count[PW-1:0];
                    count_inc = 1'b1;
                end
            end
            mtfal_pkg::ACT_REFER,
            mtfal_pkg::ACT_CONNECT,
            mtfal_pkg::ACT_ASSIGN: begin
                do_move  = fh_found;
                move_pos = fh_pos;
            end
            default: begin
            end
        endcase

        n_count = count_inc ? r_count + CW'(1) : r_count;

        n_list = r_list;
        if (do_move) begin
            n_list[0] = fh;
            for (int i = 1; i < LIST_DEPTH; i++) begin
                if (PW'(i) <= move_pos) begin
                    n_list[i] = r_list[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= '0;
            r_largest <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_count   <= n_count;
                r_largest <= n_largest;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.payload;
        end
        if (advance) begin
            r_out  <= n_out;
            r_list <= n_list;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mtfal_lookup.sv
// parallel compare of one handle against the live part of the list
`default_nettype none

module mtfal_lookup #(
    parameter int unsigned LIST_DEPTH  = 32,
    parameter int unsigned HANDLE_BITS = 32,
    parameter int unsigned PW          = 5,
    parameter int unsigned CW          = 6
) (
    input  wire logic [LIST_DEPTH-1:0][HANDLE_BITS-1:0] i_list,
    input  wire logic [CW-1:0]                          i_count,
    input  wire logic [HANDLE_BITS-1:0]                 i_handle,
    output      logic                                   o_found,
    output      logic [PW-1:0]                          o_pos
);

    logic [LIST_DEPTH-1:0] match;

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            match[i] = (i_list[i] == i_handle) && (CW'(i) < i_count);
        end
    end

    // lowest matching position wins
    always_comb begin
        o_pos = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                o_pos = PW'(i);
            end
        end
    end

    assign o_found = |match;

endmodule

`default_nettype wire

// File: rtl/core/mtfal_checker.sv
// port-level checks for the move-to-front attention list, bound to the top level
`default_nettype none

module mtfal_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire mtfal_pkg::t_out_item i_out_item
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    // running maximum covers the positions of the same transaction
    a_max_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_item.max_index >= i_out_item.source_index) &&
                        (i_out_item.max_index >= i_out_item.target_index))
        else $error("max_index below a reported position");

    // only inserting actions can drop the oldest entry
    a_drop_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.list_full_drop |->
            (i_out_item.out_action == mtfal_pkg::ACT_EVOKE) ||
            (i_out_item.out_action == mtfal_pkg::ACT_EMBED) ||
            (i_out_item.out_action == mtfal_pkg::ACT_ELABORATE))
        else $error("drop flagged on a non-insert action");

    // a miss on an action that looks nothing up is a decode slip
    a_miss_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.lookup_miss |->
            (i_out_item.out_action != mtfal_pkg::ACT_SHIFT) &&
            (i_out_item.out_action != mtfal_pkg::ACT_STOP) &&
            (i_out_item.out_action != mtfal_pkg::ACT_EVOKE))
        else $error("miss flagged on an action without lookup");

    // max_index never falls between consecutive results
    a_max_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_valid && i_out_ready) && i_out_valid && $past(i_rst_n) |->
            i_out_item.max_index >= $past(i_out_item.max_index))
        else $error("max_index decreased");

endmodule

bind move_to_front_attention_list mtfal_checker u_mtfal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);

`default_nettype wire

// File: bench/move_to_front_attention_list_test.sv
// self-checking testbench for the move-to-front attention list
module move_to_front_attention_list_test;

    localparam int LIST_DEPTH  = 32;
    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD   = 60;
    localparam int POOL_MAX    = 48;
    localparam int SEGMENT     = 50;
    localparam int FW          = mtfal_pkg::FIELD_BITS;
    localparam int IW          = mtfal_pkg::IDX_BITS;

    // mirrors the attention list and keeps the results still owed by the block
    class mtf_list_tracker;
        logic [FW-1:0]         handles [LIST_DEPTH];
        int unsigned           entries;
        logic [IW-1:0]         largest;
        mtfal_pkg::t_out_item  owed_results [$];
        int unsigned           actions_noted;
        int unsigned           results_checked;
        int unsigned           mismatches;
        int unsigned           misses_seen;
        int unsigned           drops_seen;

        function new();
            entries = 0;
            largest = '0;
        endfunction

        function int find_handle(logic [FW-1:0] h);
            for (int i = 0; i < entries; i++) begin
                if (handles[i] === h) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // position as the block reports it, with miss flag and running maximum
        function logic [IW-1:0] report_position(logic [FW-1:0] h, inout logic miss);
            int            pos;
            logic [IW-1:0] v;
            pos = find_handle(h);
            if (pos < 0) begin
                miss = 1'b1;
                v = '0;
            end else begin
                v = (pos > 31) ? 5'd31 : pos[IW-1:0];
            end
            if (v > largest) begin
                largest = v;
            end
            return v;
        endfunction

        function void bring_to_front(int pos, logic [FW-1:0] h);
            for (int i = pos; i > 0; i--) begin
                handles[i] = handles[i-1];
            end
            handles[0] = h;
        endfunction

        // returns 1 when the oldest entry falls off the end
        function logic insert_handle(logic [FW-1:0] h);
            int pos;
            pos = find_handle(h);
            if (pos >= 0) begin
                bring_to_front(pos, h);
                return 1'b0;
            end
            if (entries >= LIST_DEPTH) begin
                bring_to_front(LIST_DEPTH - 1, h);
                return 1'b1;
            end
            bring_to_front(entries, h);
            entries++;
            return 1'b0;
        endfunction

        function void note_action(mtfal_pkg::t_in_item a);
            mtfal_pkg::t_out_item r;
            logic                 miss;
            int                   pos;
            r = '0;
            miss = 1'b0;
            r.out_action = a.action;
            case (a.action)
                mtfal_pkg::ACT_EVOKE: begin
                    r.out_length = a.span_length;
                    r.out_label  = a.label_handle;
                end
                mtfal_pkg::ACT_REFER: begin
                    r.out_length   = a.span_length;
                    r.target_index = report_position(a.main_handle, miss);
                end
                mtfal_pkg::ACT_EMBED: begin
                    r.out_label    = a.label_handle;
                    r.out_role     = a.role_handle;
                    r.target_index = report_position(a.other_handle, miss);
                end
                mtfal_pkg::ACT_ELABORATE: begin
                    r.out_label    = a.label_handle;
                    r.out_role     = a.role_handle;
                    r.source_index = report_position(a.other_handle, miss);
                end
                mtfal_pkg::ACT_CONNECT: begin
                    r.source_index = report_position(a.main_handle, miss);
                    r.target_index = report_position(a.other_handle, miss);
                    r.out_role     = a.role_handle;
                end
                mtfal_pkg::ACT_ASSIGN: begin
                    r.source_index = report_position(a.main_handle, miss);
                    r.out_role     = a.role_handle;
                    r.out_label    = a.label_handle;
                end
                default: ;
            endcase
            case (a.action)
                mtfal_pkg::ACT_EVOKE, mtfal_pkg::ACT_EMBED, mtfal_pkg::ACT_ELABORATE: begin
                    r.list_full_drop = insert_handle(a.main_handle);
                end
                mtfal_pkg::ACT_REFER, mtfal_pkg::ACT_CONNECT, mtfal_pkg::ACT_ASSIGN: begin
                    // an absent handle leaves the list untouched
                    pos = find_handle(a.main_handle);
                    if (pos > 0) begin
                        bring_to_front(pos, a.main_handle);
                    end
                end
                default: ;
            endcase
            r.lookup_miss = miss;
            r.max_index   = largest;
            owed_results.insert(owed_results.size(), r);
            actions_noted++;
        endfunction

        function void compare_field(string field, logic [FW-1:0] want, logic [FW-1:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: result %0d %s mismatch, expected %0h actual %0h",
                         $time, results_checked, field, want, got);
            end
        endfunction

        function void check_result(mtfal_pkg::t_out_item got);
            mtfal_pkg::t_out_item want;
            results_checked++;
            if (got.lookup_miss === 1'b1) misses_seen++;
            if (got.list_full_drop === 1'b1) drops_seen++;
            if (owed_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected nothing actual %p", $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("out_action", FW'(want.out_action), FW'(got.out_action));
            compare_field("out_length", FW'(want.out_length), FW'(got.out_length));
            compare_field("out_label", want.out_label, got.out_label);
            compare_field("out_role", want.out_role, got.out_role);
            compare_field("source_index", FW'(want.source_index), FW'(got.source_index));
            compare_field("target_index", FW'(want.target_index), FW'(got.target_index));
            compare_field("max_index", FW'(want.max_index), FW'(got.max_index));
            compare_field("lookup_miss", FW'(want.lookup_miss), FW'(got.lookup_miss));
            compare_field("list_full_drop", FW'(want.list_full_drop),
                          FW'(got.list_full_drop));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mtfal_stream_if #(.t_payload(mtfal_pkg::t_in_item))  in_if ();
    mtfal_stream_if #(.t_payload(mtfal_pkg::t_out_item)) out_if ();

    move_to_front_attention_list DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    mtf_list_tracker list_tracker = new();

    int            sender_idle_pct;
    int            receiver_idle_pct;
    int            hold_requests;
    logic [FW-1:0] handle_pool [POOL_MAX];
    int            pool_size;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random back-pressure plus an occasional long hold-off
    initial begin
        int served;
        int hold_left;
        served = 0;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_requests != served) begin
                served++;
                hold_left = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            list_tracker.check_result(out_if.payload);
        end
    end

    // stop the run when no transaction moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results still owed",
                         $time, quiet_cycles, list_tracker.owed_results.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // called at a rising edge; returns at the edge where the action was taken
    task automatic offer_action(input mtfal_pkg::t_in_item item);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= item;
        do begin
            @(posedge i_clk);
        end while (!(in_if.valid && in_if.ready));
        list_tracker.note_action(item);
    endtask

    task automatic offer_fields(input mtfal_pkg::t_action act, input logic [31:0] frame,
                                input logic [31:0] other, input logic [7:0] len,
                                input logic [31:0] role, input logic [31:0] label);
        mtfal_pkg::t_in_item item;
        item.action       = act;
        item.main_handle  = frame;
        item.other_handle = other;
        item.span_length  = len;
        item.role_handle  = role;
        item.label_handle = label;
        offer_action(item);
    endtask

    task automatic run_directed();
        // lookups against an empty list all miss
        offer_fields(mtfal_pkg::ACT_REFER, 32'h0, 32'h0, 8'hff, 32'hffffffff, 32'hffffffff);
        offer_fields(mtfal_pkg::ACT_CONNECT, 32'hffffffff, 32'h0, 8'h00, 32'h12345678,
                     32'h0);
        offer_fields(mtfal_pkg::ACT_ASSIGN, 32'h0, 32'hffffffff, 8'h55, 32'hffffffff, 32'h0);
        offer_fields(mtfal_pkg::ACT_SHIFT, 32'hffffffff, 32'hffffffff, 8'hff, 32'hffffffff,
                     32'hffffffff);
        offer_fields(mtfal_pkg::ACT_STOP, 32'h0, 32'h0, 8'h00, 32'h0, 32'h0);
        offer_fields(mtfal_pkg::ACT_EVOKE, 32'h0, 32'hffffffff, 8'hff, 32'hffffffff,
                     32'hffffffff);
        offer_fields(mtfal_pkg::ACT_EVOKE, 32'hffffffff, 32'h0, 8'h00, 32'h0, 32'h0);
        offer_fields(mtfal_pkg::ACT_EMBED, 32'haaaa5555, 32'h0, 8'h0f, 32'hdeadbeef,
                     32'h01234567);
        offer_fields(mtfal_pkg::ACT_ELABORATE, 32'h5555aaaa, 32'hffffffff, 8'hf0, 32'h0,
                     32'hffffffff);
        offer_fields(mtfal_pkg::ACT_REFER, 32'h0, 32'h5555aaaa, 8'h80, 32'h1, 32'h2);
        offer_fields(mtfal_pkg::ACT_CONNECT, 32'hffffffff, 32'haaaa5555, 8'h01, 32'hffffffff,
                     32'h3);
        offer_fields(mtfal_pkg::ACT_ASSIGN, 32'haaaa5555, 32'h0, 8'h7f, 32'h0badf00d,
                     32'hcafe0001);
        // re-insert of a present handle only moves it
        offer_fields(mtfal_pkg::ACT_EVOKE, 32'h0, 32'h0, 8'h33, 32'h0, 32'h0f0f0f0f);
        // move to front of an absent handle
        offer_fields(mtfal_pkg::ACT_REFER, 32'h00012345, 32'h0, 8'h22, 32'h0, 32'h0);
        offer_fields(mtfal_pkg::ACT_CONNECT, 32'h5555aaaa, 32'h00054321, 8'h0, 32'h77, 32'h0);
        offer_fields(mtfal_pkg::ACT_EMBED, 32'hffffffff, 32'h87654321, 8'h0, 32'hf00f,
                     32'h0ff0);
        offer_fields(mtfal_pkg::ACT_ELABORATE, 32'h13579bdf, 32'h0, 8'h0, 32'h1, 32'h1);
        // handle already at the front
        offer_fields(mtfal_pkg::ACT_REFER, 32'h13579bdf, 32'h0, 8'hc3, 32'h0, 32'h0);
        offer_fields(mtfal_pkg::ACT_ASSIGN, 32'h13579bdf, 32'h13579bdf, 8'h3c, 32'hffffffff,
                     32'hffffffff);
        offer_fields(mtfal_pkg::ACT_STOP, 32'h13579bdf, 32'h0, 8'hff, 32'hffffffff,
                     32'hffffffff);
    endtask

    function automatic logic [31:0] fresh_handle();
        int pick;
        pick = int'($urandom_range(15));
        if (pick == 0) return 32'h0;
        if (pick == 1) return 32'hffffffff;
        return $urandom;
    endfunction

    // new segment: list sizes from a few entries to well past the depth
    function automatic void refresh_pool();
        pool_size = int'($urandom_range(POOL_MAX, 4));
        for (int i = 0; i < POOL_MAX; i++) begin
            if ($urandom_range(1) == 0) begin
                handle_pool[i] = fresh_handle();
            end
        end
    endfunction

    function automatic logic [31:0] pick_handle();
        if ($urandom_range(99) < 85) begin
            return handle_pool[$urandom_range(pool_size - 1)];
        end
        return fresh_handle();
    endfunction

    function automatic mtfal_pkg::t_action pick_action();
        int roll;
        roll = int'($urandom_range(99));
        if (roll < 7)  return mtfal_pkg::ACT_SHIFT;
        if (roll < 14) return mtfal_pkg::ACT_STOP;
        if (roll < 30) return mtfal_pkg::ACT_EVOKE;
        if (roll < 45) return mtfal_pkg::ACT_REFER;
        if (roll < 58) return mtfal_pkg::ACT_EMBED;
        if (roll < 70) return mtfal_pkg::ACT_ELABORATE;
        if (roll < 85) return mtfal_pkg::ACT_CONNECT;
        return mtfal_pkg::ACT_ASSIGN;
    endfunction

    task automatic run_random(input int count);
        mtfal_pkg::t_in_item item;
        for (int n = 0; n < count; n++) begin
            if (n % SEGMENT == 0) begin
                refresh_pool();
            end
            item.action       = pick_action();
            item.main_handle  = pick_handle();
            item.other_handle = pick_handle();
            item.span_length  = 8'($urandom_range(255));
            item.role_handle  = $urandom;
            item.label_handle = $urandom;
            offer_action(item);
        end
    endtask

    initial begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_requests     = 0;
        pool_size         = POOL_MAX;
        for (int i = 0; i < POOL_MAX; i++) begin
            handle_pool[i] = $urandom;
        end
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        sender_idle_pct   = 16;
        receiver_idle_pct = 80;
        run_random(300);

        sender_idle_pct   = 80;
        receiver_idle_pct = 16;
        run_random(300);

        // full rate, starting with a long receiver hold-off so the input backs up
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_requests++;
        run_random(350);
        in_if.valid <= 1'b0;

        while (list_tracker.owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);

        $display("run: %0d actions, %0d results checked, %0d mismatches",
                 list_tracker.actions_noted, list_tracker.results_checked,
                 list_tracker.mismatches);
        $display("run: %0d lookup misses and %0d full-list drops seen, max position %0d",
                 list_tracker.misses_seen, list_tracker.drops_seen, list_tracker.largest);
        if (list_tracker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
